@@ rtl/reciprocal_frequency_meter_defines.svh @@
// Assertion macros for the reciprocal frequency meter.
// Used by the top level only; needs no other file.
`ifndef RECIPROCAL_FREQUENCY_METER_DEFINES_SVH
`define RECIPROCAL_FREQUENCY_METER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define RFM_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define RFM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/rfm_pkg.sv @@
// Shared widths, codes and structs of the reciprocal frequency meter.
// No dependencies; every module refers to it by scoped names.
package rfm_pkg;

  localparam int FRAC_BITS  = 8;
  localparam int TIMER_BITS = 16;
  localparam int OVF_W      = 16;
  localparam int STAMP_W    = 32;
  localparam int FREQ_W     = 32;
  localparam int CLK_W      = 24;
  localparam int PER_W      = 32;
  localparam int TMO_W      = 16;
  localparam int SHIFT_W    = 3;
  localparam int MS_W       = 17;

  // divider: dividend is the clock rate shifted up by the fraction bits
  localparam int DIV_W  = CLK_W + FRAC_BITS;
  localparam int Q_W    = (DIV_W > FREQ_W) ? DIV_W : FREQ_W;
  localparam int DCNT_W = $clog2(Q_W + 1);

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // stream and config port widths
  localparam int FUNC_W      = 2;
  localparam int IN_TDATA_W  = ((TIMER_BITS + 1 + 7) / 8) * 8;
  localparam int IN_TUSER_W  = FUNC_W;
  localparam int OUT_TDATA_W = 2 * FREQ_W;
  localparam int OUT_TUSER_W = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  // register reset values
  localparam logic [CLK_W-1:0] CLOCK_HZ_RST   = CLK_W'(2000000);
  localparam logic [PER_W-1:0] MIN_PERIOD_RST = PER_W'(200);
  localparam logic [PER_W-1:0] MAX_PERIOD_RST = PER_W'(66666);
  localparam logic [TMO_W-1:0] TIMEOUT_RST    = TMO_W'(120);
  localparam logic [SHIFT_W-1:0] EMA_SHIFT_RST = SHIFT_W'(2);

  typedef enum logic [FUNC_W-1:0] {
    FN_OVERFLOW = 2'd0,
    FN_CAPTURE  = 2'd1,
    FN_TICK     = 2'd2,
    FN_READ     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_NONE    = 2'd0,
    ST_VALID   = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLOCK_HZ   = 3'd0,
    CFG_MIN_PERIOD = 3'd1,
    CFG_MAX_PERIOD = 3'd2,
    CFG_TIMEOUT    = 3'd3,
    CFG_EMA_SHIFT  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [CLK_W-1:0]   timer_clock_hz;
    logic [PER_W-1:0]   min_period_ticks;
    logic [PER_W-1:0]   max_period_ticks;
    logic [TMO_W-1:0]   timeout_ms;
    logic [SHIFT_W-1:0] ema_shift;
  } cfg_t;

  // one classified event waiting in the queue
  typedef struct packed {
    func_e                 kind;
    logic [TIMER_BITS-1:0] cap;
    logic                  bump;   // pending overflow belongs to this capture
  } entry_t;

  typedef struct packed {
    logic           start;
    logic [Q_W-1:0] dividend;
    logic [PER_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [Q_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/rfm_front.sv @@
// Front end: accepts input beats and classifies them into queue entries.
// Depends on rfm_pkg.
module rfm_front (
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: capture_value [TIMER_BITS-1:0], overflow_pending [TIMER_BITS]
  input  logic [rfm_pkg::IN_TDATA_W-1:0] s_axis_tdata_i,
  // tuser: func [1:0]
  input  logic [rfm_pkg::IN_TUSER_W-1:0] s_axis_tuser_i,
  input  logic                           q_full_i,
  output logic                           q_push_o,
  output rfm_pkg::entry_t                q_entry_o
);

  logic [rfm_pkg::TIMER_BITS-1:0] cap;
  logic                           pending;

  assign cap     = s_axis_tdata_i[rfm_pkg::TIMER_BITS-1:0];
  assign pending = s_axis_tdata_i[rfm_pkg::TIMER_BITS];

  // take a beat whenever the queue has room
  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;

  // overflow race: a pending overflow counts for a capture in the lower half
  always_comb begin
    q_entry_o.kind = rfm_pkg::func_e'(s_axis_tuser_i);
    q_entry_o.cap  = cap;
    q_entry_o.bump = pending && !cap[rfm_pkg::TIMER_BITS-1] &&
                     (rfm_pkg::func_e'(s_axis_tuser_i) == rfm_pkg::FN_CAPTURE);
  end

endmodule

@@ rtl/rfm_fifo.sv @@
// Short queue of classified events between front and back.
// Depends on rfm_pkg.
module rfm_fifo (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  rfm_pkg::entry_t                entry_i,
  input  logic                           pop_i,
  output rfm_pkg::entry_t                entry_o,
  output logic                           full_o,
  output logic                           empty_o,
  output logic [rfm_pkg::FIFO_CNT_W-1:0] count_o
);

  rfm_pkg::entry_t                  mem_q [rfm_pkg::FIFO_DEPTH];
  logic [rfm_pkg::FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [rfm_pkg::FIFO_CNT_W-1:0]   cnt_q;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_q == rfm_pkg::FIFO_CNT_W'(rfm_pkg::FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign entry_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == rfm_pkg::FIFO_PTR_W'(rfm_pkg::FIFO_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == rfm_pkg::FIFO_PTR_W'(rfm_pkg::FIFO_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

@@ rtl/rfm_div.sv @@
// Restoring serial divider, one quotient bit per cycle.
// Depends on rfm_pkg; the divisor is never zero when started.
module rfm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rfm_pkg::div_req_t req_i,
  output rfm_pkg::div_rsp_t rsp_o
);

  logic                          busy_q, done_q;
  logic [rfm_pkg::DCNT_W-1:0]    cnt_q;
  logic [rfm_pkg::PER_W-1:0]     rem_q, dvs_q;
  logic [rfm_pkg::Q_W-1:0]       quo_q;
  logic [rfm_pkg::PER_W:0]       trial;
  logic                          fits;

  // shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quo_q[rfm_pkg::Q_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      dvs_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        rem_q <= fits ? rfm_pkg::PER_W'(trial - {1'b0, dvs_q})
                      : trial[rfm_pkg::PER_W-1:0];
        quo_q <= {quo_q[rfm_pkg::Q_W-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == rfm_pkg::DCNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= rfm_pkg::DCNT_W'(rfm_pkg::Q_W);
        rem_q  <= '0;
        dvs_q  <= req_i.divisor;
        quo_q  <= req_i.dividend;
      end
    end
  end

endmodule

@@ rtl/rfm_back.sv @@
// Back end: meter state, period check, EMA and the output register.
// Depends on rfm_pkg; the divider sits beside it in the top level.
module rfm_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rfm_pkg::cfg_t                   cfg_i,
  input  rfm_pkg::entry_t                 q_entry_i,
  input  logic                            q_empty_i,
  output logic                            q_pop_o,
  output rfm_pkg::div_req_t               div_req_o,
  input  rfm_pkg::div_rsp_t               div_rsp_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tdata: smoothed_freq [31:0], raw_freq [63:32]
  output logic [rfm_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: status [1:0], period_accepted [2]
  output logic [rfm_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_EMA_STEP,
    S_EMA_ADD,
    S_RESULT
  } state_e;

  state_e                          state_q;
  logic [rfm_pkg::OVF_W-1:0]       ovf_q;
  logic [rfm_pkg::STAMP_W-1:0]     prev_q, ticks_q;
  logic                            primed_q, avg_valid_q, acc_q, start_q;
  logic [rfm_pkg::FREQ_W-1:0]      avg_q, raw_q, step_q;
  logic [rfm_pkg::MS_W-1:0]        ms_q;
  logic                            m_valid_q;
  logic [rfm_pkg::FREQ_W-1:0]      out_smooth_q, out_raw_q;
  rfm_pkg::status_e                out_status_q;
  logic                            out_acc_q;

  logic [rfm_pkg::OVF_W-1:0]              ovf_used;
  logic [rfm_pkg::OVF_W+rfm_pkg::TIMER_BITS-1:0] stamp_wide;
  logic [rfm_pkg::STAMP_W-1:0]            stamp_d;
  logic                                   in_band_d;
  logic [rfm_pkg::FREQ_W-1:0]             raw_sat_d;
  logic signed [rfm_pkg::FREQ_W:0]        diff_d, step_d;
  logic                                   out_free;
  rfm_pkg::status_e                       status_d;
  logic [rfm_pkg::FREQ_W-1:0]             smooth_d;
  localparam logic [rfm_pkg::Q_W-1:0] RawMax = rfm_pkg::Q_W'(32'hFFFF_FFFF);

  // timestamp from overflow epoch and captured value
  assign ovf_used   = q_entry_i.bump ? ovf_q + 1'b1 : ovf_q;
  assign stamp_wide = {ovf_used, q_entry_i.cap};
  assign stamp_d    = stamp_wide[rfm_pkg::STAMP_W-1:0];

  // band check on the registered period
  assign in_band_d = (ticks_q != '0) && (ticks_q >= cfg_i.min_period_ticks) &&
                     (ticks_q <= cfg_i.max_period_ticks);

  // quotient saturates at the output width
  assign raw_sat_d = (div_rsp_i.quotient > RawMax) ? '1
                                                   : div_rsp_i.quotient[rfm_pkg::FREQ_W-1:0];

  // EMA step: arithmetic shift floors negative differences
  assign diff_d = $signed({1'b0, raw_q}) - $signed({1'b0, avg_q});
  assign step_d = diff_d >>> cfg_i.ema_shift;

  // result view of the current state
  always_comb begin
    if (ms_q > rfm_pkg::MS_W'(cfg_i.timeout_ms)) begin
      status_d = rfm_pkg::ST_TIMEOUT;
      smooth_d = '0;
    end else if (!avg_valid_q) begin
      status_d = rfm_pkg::ST_NONE;
      smooth_d = '0;
    end else begin
      status_d = rfm_pkg::ST_VALID;
      smooth_d = avg_q;
    end
  end

  assign out_free = !m_valid_q || m_axis_tready_i;
  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i;

  assign div_req_o.start    = start_q;
  assign div_req_o.dividend = rfm_pkg::Q_W'(cfg_i.timer_clock_hz) << rfm_pkg::FRAC_BITS;
  assign div_req_o.divisor  = ticks_q;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {out_raw_q, out_smooth_q};
  assign m_axis_tuser_o  = {out_acc_q, out_status_q};

  // sequencer, meter state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ovf_q        <= '0;
      prev_q       <= '0;
      ticks_q      <= '0;
      primed_q     <= 1'b0;
      avg_valid_q  <= 1'b0;
      acc_q        <= 1'b0;
      start_q      <= 1'b0;
      avg_q        <= '0;
      raw_q        <= '0;
      step_q       <= '0;
      ms_q         <= '0;
      m_valid_q    <= 1'b0;
      out_smooth_q <= '0;
      out_raw_q    <= '0;
      out_status_q <= rfm_pkg::ST_NONE;
      out_acc_q    <= 1'b0;
    end else begin
      // taken beat clears valid; S_RESULT loads the next one itself
      if (m_valid_q && m_axis_tready_i && (state_q != S_RESULT)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            acc_q   <= 1'b0;
            state_q <= S_RESULT;
            unique case (q_entry_i.kind)
              rfm_pkg::FN_OVERFLOW: begin
                ovf_q <= ovf_q + 1'b1;
              end
              rfm_pkg::FN_CAPTURE: begin
                prev_q <= stamp_d;
                if (!primed_q) begin
                  primed_q <= 1'b1;
                end else begin
                  ticks_q <= stamp_d - prev_q;
                  state_q <= S_CHECK;
                end
              end
              rfm_pkg::FN_TICK: begin
                if (ms_q != '1) begin
                  ms_q <= ms_q + 1'b1;
                end
              end
              default: begin
                // read: result only
              end
            endcase
          end
        end
        S_CHECK: begin
          if (in_band_d) begin
            start_q <= 1'b1;
            state_q <= S_DIV;
          end else begin
            state_q <= S_RESULT;
          end
        end
        S_DIV: begin
          start_q <= 1'b0;
          if (div_rsp_i.done) begin
            raw_q <= raw_sat_d;
            ms_q  <= '0;
            acc_q <= 1'b1;
            if (!avg_valid_q) begin
              avg_q       <= raw_sat_d;
              avg_valid_q <= 1'b1;
              state_q     <= S_RESULT;
            end else begin
              state_q <= S_EMA_STEP;
            end
          end
        end
        S_EMA_STEP: begin
          step_q  <= step_d[rfm_pkg::FREQ_W-1:0];
          state_q <= S_EMA_ADD;
        end
        S_EMA_ADD: begin
          avg_q   <= avg_q + step_q;
          state_q <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            m_valid_q    <= 1'b1;
            out_smooth_q <= smooth_d;
            out_raw_q    <= raw_q;
            out_status_q <= status_d;
            out_acc_q    <= acc_q;
            state_q      <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/reciprocal_frequency_meter.sv @@
// Top level of the reciprocal frequency meter: config registers, front,
// queue, back and divider. Depends on rfm_pkg and the defines header.
//
//  channel  | dir | handshake                       | content
//  s_axis   | in  | s_axis_tvalid_i / s_axis_tready_o | event: func, capture, pending
//  m_axis   | out | m_axis_tvalid_o / m_axis_tready_i | smoothed, raw, status, accepted
//  cfg      | in  | cfg_valid_i / cfg_ready_o         | register index and write data
//
// In the back end, overflow, tick, read and priming capture go from idle to
// result, an out-of-band capture via check; an in-band capture also waits in
// divide on the one-bit-a-cycle divider, then EMA step and add unless seeding.
// Reset is asynchronous, active low, and clears all meter state; no clearing pass.
// The output register holds a result until it is taken; the back end then waits
// and the two-entry queue, once full, stalls the input.
`include "reciprocal_frequency_meter_defines.svh"

module reciprocal_frequency_meter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // tdata: capture_value [15:0], overflow_pending [16], zero fill [23:17]
  input  logic [rfm_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: func [1:0]
  input  logic [rfm_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // tdata: smoothed_freq [31:0], raw_freq [63:32]
  output logic [rfm_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // tuser: status [1:0], period_accepted [2]
  output logic [rfm_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [rfm_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rfm_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  rfm_pkg::cfg_t                  cfg_q;
  rfm_pkg::entry_t                push_entry, head_entry;
  logic                           q_push, q_pop, q_full, q_empty;
  logic [rfm_pkg::FIFO_CNT_W-1:0] q_count;
  rfm_pkg::div_req_t              div_req;
  rfm_pkg::div_rsp_t              div_rsp;

  // configuration registers, unknown indexes ignored
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timer_clock_hz   <= rfm_pkg::CLOCK_HZ_RST;
      cfg_q.min_period_ticks <= rfm_pkg::MIN_PERIOD_RST;
      cfg_q.max_period_ticks <= rfm_pkg::MAX_PERIOD_RST;
      cfg_q.timeout_ms       <= rfm_pkg::TIMEOUT_RST;
      cfg_q.ema_shift        <= rfm_pkg::EMA_SHIFT_RST;
    end else if (cfg_valid_i) begin
      unique case (rfm_pkg::cfg_idx_e'(cfg_index_i))
        rfm_pkg::CFG_CLOCK_HZ:   cfg_q.timer_clock_hz   <= cfg_data_i[rfm_pkg::CLK_W-1:0];
        rfm_pkg::CFG_MIN_PERIOD: cfg_q.min_period_ticks <= cfg_data_i[rfm_pkg::PER_W-1:0];
        rfm_pkg::CFG_MAX_PERIOD: cfg_q.max_period_ticks <= cfg_data_i[rfm_pkg::PER_W-1:0];
        rfm_pkg::CFG_TIMEOUT:    cfg_q.timeout_ms       <= cfg_data_i[rfm_pkg::TMO_W-1:0];
        rfm_pkg::CFG_EMA_SHIFT:  cfg_q.ema_shift        <= cfg_data_i[rfm_pkg::SHIFT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rfm_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_entry_o       (push_entry)
  );

  rfm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .pop_i   (q_pop),
    .entry_o (head_entry),
    .full_o  (q_full),
    .empty_o (q_empty),
    .count_o (q_count)
  );

  rfm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  rfm_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_entry_i       (head_entry),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .div_req_o       (div_req),
    .div_rsp_i       (div_rsp),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // checks on queue and divider coupling
  `RFM_ASSERT_IMPL(a_fifo_bound, clk_i, rst_ni, 1'b1, q_count <= rfm_pkg::FIFO_CNT_W'(rfm_pkg::FIFO_DEPTH), "queue fill count above depth")
  `RFM_ASSERT_IMPL(a_full_stall, clk_i, rst_ni, q_full, !s_axis_tready_o, "input ready while queue is full")
  `RFM_ASSERT_IMPL(a_pop_idle_div, clk_i, rst_ni, q_pop, !div_rsp.busy, "event popped while divider busy")
  `RFM_ASSERT_NEXT(a_div_starts, clk_i, rst_ni, div_req.start && !div_rsp.busy, div_rsp.busy, "divider did not start")

endmodule
